// File: rtl/lbpr_pkg.sv
// Package with the constants and types shared by the balanced parenthesis run block.
`default_nettype none

package lbpr_pkg;

    // Longest string that is processed; later bytes only set the overflow flag.
    localparam int MAX_LEN     = 1024;
    // The stack holds the seed entry plus at most one entry per byte.
    localparam int STACK_DEPTH = MAX_LEN + 1;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 11;
    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // Byte code of the opening parenthesis; every other byte closes.
    localparam logic [CHAR_W-1:0] OPEN_CODE = 8'd40;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

endpackage

`default_nettype wire

// File: rtl/lbpr_in_if.sv
// Valid/ready channel that carries one character of the input string.
`default_nettype none

interface lbpr_in_if;
    import lbpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              start_of_string;

    modport source (output valid, output char_code, output start_of_string, input ready);
    modport sink   (input valid, input char_code, input start_of_string, output ready);
endinterface

`default_nettype wire

// File: rtl/lbpr_out_if.sv
// Valid/ready channel that carries one result of the balanced parenthesis run block.
`default_nettype none

interface lbpr_out_if;
    import lbpr_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] longest_so_far;
    logic             overflow;

    modport source (output valid, output longest_so_far, output overflow, input ready);
    modport sink   (input valid, input longest_so_far, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/longest_balanced_paren_run.sv
// Top level of the longest balanced parenthesis run block.
`default_nettype none

// A character transaction accepted into the input register moves on to the output
// register when the output stage is free or its result is being taken.
// Throughput: one character per cycle while the output is not stalled; the stack top,
// second and third entries are cached in registers, so each byte needs at most one
// stack memory write and one registered read.
// Reset: asynchronous, active low; it empties both stages and sets the stack to the seed entry.
module longest_balanced_paren_run_core (
    input  wire         clk,
    input  wire         rst_n,
    lbpr_in_if.sink     chars,
    lbpr_out_if.source  results
);
    import lbpr_pkg::*;

    // Input stage.
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              start_reg;

    // Output stage.
    logic              out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]  longest_reg;
    logic              overflow_reg;

    // Scan state: stack count, cached top entries, position, best length.
    cnt_t count_reg, count_next;
    pos_t top_reg, top_next;
    pos_t second_reg, second_next;
    pos_t position_reg, position_next;
    pos_t best_reg, best_next;
    logic ovf_reg, ovf_next;
    logic seed_reg, seed_next;

    // Stack memory and its registered read port.
    pos_t  stack_mem [STACK_DEPTH];
    pos_t  rd_data_reg;
    logic  third_seed_reg;
    addr_t rd_addr;
    addr_t wr_addr;
    logic  wr_en;
    logic  advance;

    // State of this string once a start flag has been applied.
    cnt_t count_e;
    pos_t top_e, second_e, third_e, position_e, best_e, here, run;
    logic ovf_e, seed_e;

    // Handshake: the input stage moves forward whenever the output stage is free or its result is taken.
    assign advance     = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (chars.valid && chars.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // The third entry comes from memory, or is the seed when it sits at index zero.
    assign third_e = third_seed_reg ? '0 : rd_data_reg;

    // Apply the start flag, then handle the byte.
    always_comb
    begin
        if (start_reg)
        begin
            count_e    = CNT_W'(1);
            top_e      = '0;
            second_e   = '0;
            position_e = '0;
            best_e     = '0;
            ovf_e      = 1'b0;
            seed_e     = 1'b1;
        end
        else
        begin
            count_e    = count_reg;
            top_e      = top_reg;
            second_e   = second_reg;
            position_e = position_reg;
            best_e     = best_reg;
            ovf_e      = ovf_reg;
            seed_e     = seed_reg;
        end

        here = position_e + POS_W'(1);
        run  = here - second_e;

        count_next    = count_reg;
        top_next      = top_reg;
        second_next   = second_reg;
        position_next = position_reg;
        best_next     = best_reg;
        ovf_next      = ovf_reg;
        seed_next     = seed_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;

        if (advance)
        begin
            count_next    = count_e;
            top_next      = top_e;
            second_next   = second_e;
            position_next = position_e;
            best_next     = best_e;
            ovf_next      = ovf_e;
            seed_next     = seed_e;

            if (32'(position_e) >= MAX_LEN)
            begin
                // The string is too long: the byte is dropped.
                ovf_next = 1'b1;
            end
            else
            begin
                position_next = here;
                if (char_reg == OPEN_CODE)
                begin
                    // Push this byte's position.
                    count_next  = count_e + CNT_W'(1);
                    top_next    = here;
                    second_next = top_e;
                    wr_en       = 1'b1;
                    wr_addr     = ADDR_W'(count_e);
                end
                else if (count_e <= CNT_W'(1))
                begin
                    // The pop empties the stack: this byte becomes the new base.
                    count_next = CNT_W'(1);
                    top_next   = here;
                    seed_next  = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end
                else
                begin
                    // Pop and measure the run back to the new top.
                    count_next  = count_e - CNT_W'(1);
                    top_next    = second_e;
                    second_next = third_e;
                    if (run > best_e)
                    begin
                        best_next = run;
                    end
                end
            end
        end

        // Fetch the entry that lies under the next second entry.
        if (count_next >= CNT_W'(3))
        begin
            rd_addr = ADDR_W'(count_next - CNT_W'(3));
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Stack memory: at most one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= here;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg  <= chars.char_code;
            start_reg <= chars.start_of_string;
        end
        if (advance)
        begin
            longest_reg  <= LEN_W'(best_next);
            overflow_reg <= ovf_next;
        end
    end

    // Control state, with the cached stack entries holding the seed after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= CNT_W'(1);
            top_reg        <= '0;
            second_reg     <= '0;
            position_reg   <= '0;
            best_reg       <= '0;
            ovf_reg        <= 1'b0;
            seed_reg       <= 1'b1;
            third_seed_reg <= 1'b1;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            second_reg     <= second_next;
            position_reg   <= position_next;
            best_reg       <= best_next;
            ovf_reg        <= ovf_next;
            seed_reg       <= seed_next;
            third_seed_reg <= seed_next && (rd_addr == '0);
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.longest_so_far = longest_reg;
    assign results.overflow       = overflow_reg;

endmodule

`default_nettype wire

// File: rtl/lbpr_checker.sv
// Port-level assertions for the balanced parenthesis run block and their bind.
`default_nettype none

module lbpr_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [lbpr_pkg::LEN_W-1:0]   longest_so_far,
    input wire                         overflow
);
    import lbpr_pkg::*;

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(longest_so_far) && $stable(overflow))
        else $error("result payload changed while stalled");

    // A balanced run always has even length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !longest_so_far[0])
        else $error("odd balanced run length");

    // The length never exceeds the longest string handled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(longest_so_far) <= MAX_LEN))
        else $error("run length beyond the string limit");

    // With the output stage empty the block always takes a character.
    assert property (@(posedge clk)
        !out_valid |-> in_ready)
        else $error("input stalled while the output stage is empty");

    // A character accepted while the output is empty leads to a valid result after the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("accepted character gave no result");

endmodule

bind longest_balanced_paren_run_core lbpr_checker u_lbpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (chars.valid),
    .in_ready       (chars.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .longest_so_far (results.longest_so_far),
    .overflow       (results.overflow)
);

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the longest balanced parenthesis run core.

module tb;
    import lbpr_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [CHAR_W-1:0] CLOSE_CODE = 8'd41;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [LEN_W-1:0] longest;
        logic             ovf;
    } run_result_t;

    // One row of the directed stimulus; typed rows carry their own expectation.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              sos;
        logic              typed;
        logic [LEN_W-1:0]  longest;
        logic              ovf;
    } stim_row_t;

    localparam int NUM_ROWS = 22;

    logic clk = 1'b0;
    logic rst_n;

    lbpr_in_if  chars_if ();
    lbpr_out_if results_if ();

    longest_balanced_paren_run_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Tracker state: stack of base positions (index + 1) and string counters.
    pos_t             base_store [STACK_DEPTH];
    cnt_t             store_depth;
    pos_t             string_pos;
    logic [LEN_W-1:0] best_run;
    logic             overflow_seen;

    run_result_t pending_runs [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_request = 0;
    bit          typed_check = 1'b0;
    run_result_t typed_result = '0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{CLOSE_CODE, 1'b0, 1'b1, 11'd0, 1'b0},
        '{OPEN_CODE,  1'b0, 1'b1, 11'd0, 1'b0},
        '{CLOSE_CODE, 1'b0, 1'b1, 11'd2, 1'b0},
        '{OPEN_CODE,  1'b0, 1'b1, 11'd2, 1'b0},
        '{8'hFF,      1'b0, 1'b1, 11'd4, 1'b0},
        '{8'h00,      1'b0, 1'b0, 11'd0, 1'b0},
        '{OPEN_CODE,  1'b1, 1'b1, 11'd0, 1'b0},
        '{OPEN_CODE,  1'b0, 1'b0, 11'd0, 1'b0},
        '{OPEN_CODE,  1'b0, 1'b0, 11'd0, 1'b0},
        '{CLOSE_CODE, 1'b0, 1'b0, 11'd0, 1'b0},
        '{8'd39,      1'b0, 1'b0, 11'd0, 1'b0},
        '{CLOSE_CODE, 1'b0, 1'b1, 11'd6, 1'b0},
        '{8'h80,      1'b0, 1'b0, 11'd0, 1'b0},
        '{8'h7F,      1'b1, 1'b1, 11'd0, 1'b0},
        '{OPEN_CODE,  1'b0, 1'b0, 11'd0, 1'b0},
        '{8'hAA,      1'b0, 1'b0, 11'd0, 1'b0},
        '{OPEN_CODE,  1'b0, 1'b0, 11'd0, 1'b0},
        '{8'h55,      1'b0, 1'b0, 11'd0, 1'b0},
        '{8'hFE,      1'b0, 1'b0, 11'd0, 1'b0},
        '{OPEN_CODE,  1'b1, 1'b1, 11'd0, 1'b0},
        '{8'h01,      1'b0, 1'b0, 11'd0, 1'b0},
        '{8'h29,      1'b0, 1'b0, 11'd0, 1'b0}
    };

    // Back to the state of an empty string: only the base for index -1 remains.
    function automatic void clear_run_tracker();
        base_store[0] = '0;
        store_depth   = cnt_t'(1);
        string_pos    = '0;
        best_run      = '0;
        overflow_seen = 1'b0;
    endfunction

    // Applies one character to the tracker and returns the result it causes.
    function automatic run_result_t advance_run_tracker(input logic [CHAR_W-1:0] ch,
                                                        input logic sos);
        pos_t        here;
        pos_t        top;
        run_result_t res;
        if (sos)
            clear_run_tracker();
        if (int'(string_pos) >= MAX_LEN)
        begin
            overflow_seen = 1'b1;
        end
        else
        begin
            here = string_pos + pos_t'(1);
            if (ch == OPEN_CODE)
            begin
                if (int'(store_depth) < STACK_DEPTH)
                begin
                    base_store[store_depth] = here;
                    store_depth = store_depth + cnt_t'(1);
                end
            end
            else
            begin
                if (store_depth != '0)
                    store_depth = store_depth - cnt_t'(1);
                if (store_depth == '0)
                begin
                    base_store[0] = here;
                    store_depth = cnt_t'(1);
                end
                else
                begin
                    top = base_store[store_depth - cnt_t'(1)];
                    if (here >= top && LEN_W'(here - top) > best_run)
                        best_run = LEN_W'(here - top);
                end
            end
            string_pos = here;
        end
        res.longest = best_run;
        res.ovf     = overflow_seen;
        return res;
    endfunction

    // Predict on every accepted character, check every accepted result.
    always @(posedge clk)
    begin : run_checker
        run_result_t predicted;
        run_result_t wanted;
        if (rst_n)
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                predicted = advance_run_tracker(chars_if.char_code, chars_if.start_of_string);
                pending_runs.push_back(typed_check ? typed_result : predicted);
            end
            if (results_if.valid && results_if.ready)
            begin
                if (pending_runs.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    error_count++;
                end
                else
                begin
                    wanted = pending_runs.pop_front();
                    if (results_if.longest_so_far !== wanted.longest)
                    begin
                        $error("longest_so_far: expected %0d, got %0d",
                               wanted.longest, results_if.longest_so_far);
                        error_count++;
                    end
                    if (results_if.overflow !== wanted.ovf)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               wanted.ovf, results_if.overflow);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready)
                   || (results_if.valid && results_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            else
            begin
                results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offers one character transaction; entered and left just after a falling edge.
    task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic sos,
                              input bit typed, input run_result_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.valid           <= 1'b1;
        chars_if.char_code       <= ch;
        chars_if.start_of_string <= sos;
        typed_check  = typed;
        typed_result = typed_res;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_for_results();
        chars_if.valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(negedge clk);
    endtask

    // Any byte that closes, mostly the closing parenthesis itself.
    function automatic logic [CHAR_W-1:0] closing_byte();
        logic [CHAR_W-1:0] ch;
        ch = CHAR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0 || ch == OPEN_CODE)
            ch = CLOSE_CODE;
        return ch;
    endfunction

    // Random strings: mostly nearly balanced, some coin-flip parens, some raw bytes.
    task automatic send_random_strings(input int item_goal, input int hold_at);
        int                sent;
        int                len;
        int                mode;
        int                depth;
        logic [CHAR_W-1:0] ch;
        logic              sos;
        sent = 0;
        while (sent < item_goal)
        begin
            mode  = $urandom_range(0, 99);
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                : $urandom_range(1, 24);
            depth = 0;
            for (int i = 0; i < len; i++)
            begin
                if (sent == hold_at)
                    hold_request = HOLD_CYCLES;
                if (mode < 15)
                    ch = CHAR_W'($urandom_range(0, 255));
                else if (mode < 40)
                    ch = $urandom_range(0, 1) ? OPEN_CODE : closing_byte();
                else if ((depth == 0 && $urandom_range(0, 19) != 0)
                         || $urandom_range(0, 99) < 50)
                    ch = OPEN_CODE;
                else
                    ch = closing_byte();
                if (ch == OPEN_CODE)
                    depth++;
                else if (depth > 0)
                    depth--;
                sos = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 99) == 0);
                offer_char(ch, sos, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // One fully nested string of the maximum length, then bytes past the limit.
    task automatic send_overlong_string();
        for (int i = 0; i < MAX_LEN / 2; i++)
            offer_char(OPEN_CODE, i == 0, 1'b0, '0);
        for (int i = 0; i < MAX_LEN / 2; i++)
            offer_char(CLOSE_CODE, 1'b0, 1'b0, '0);
        offer_char(OPEN_CODE, 1'b0, 1'b1, run_result_t'{LEN_W'(MAX_LEN), 1'b1});
        for (int i = 0; i < 5; i++)
            offer_char(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        offer_char(CLOSE_CODE, 1'b1, 1'b1, run_result_t'{LEN_W'(0), 1'b0});
    endtask

    // Main sequence: reset, directed table, then random strings under three idling settings, the last with no idling.
    initial
    begin
        chars_if.valid           = 1'b0;
        chars_if.char_code       = '0;
        chars_if.start_of_string = 1'b0;
        rst_n = 1'b0;
        clear_run_tracker();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 68;
        for (int r = 0; r < NUM_ROWS; r++)
            offer_char(directed_rows[r].ch, directed_rows[r].sos, directed_rows[r].typed,
                       run_result_t'{directed_rows[r].longest, directed_rows[r].ovf});
        wait_for_results();
        send_random_strings(220, 60);
        wait_for_results();

        send_idle_pct = 68;
        recv_idle_pct = 38;
        send_random_strings(210, -1);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_strings(200, -1);
        send_overlong_string();
        send_random_strings(30, -1);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
